@@ rtl/core/fbv_pkg.sv @@
// ----------------------------------------------------------------------------
// fbv_pkg
// Shared constants and types for the face visibility / alpha pipeline.
// ----------------------------------------------------------------------------
package fbv_pkg;

  localparam int UNIT_BITS  = 30;
  localparam int UNIT_W     = UNIT_BITS + 2;
  localparam int SQ_W       = 2 * UNIT_BITS + 2;
  localparam int ROOT_W     = UNIT_BITS + 1;
  localparam int SQRT_STEPS = UNIT_BITS + 1;
  localparam int DIV_STEPS  = UNIT_BITS + 1;
  localparam int DIV_W      = 2 * UNIT_BITS + 1;
  localparam int DOT_W      = 2 * UNIT_W;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_DIST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_HIGH = 2'd2;

  localparam logic        [CFG_W-1:0] VIEW_DIST_RST = 16'd1000;
  localparam logic signed [CFG_W-1:0] FADE_LOW_RST  = -16'sd4915;
  localparam logic signed [CFG_W-1:0] FADE_HIGH_RST = 16'sd4915;

  localparam int              ALPHA_W   = 8;
  localparam logic [ALPHA_W-1:0] ALPHA_MAX = 8'd255;

  typedef logic signed [UNIT_W-1:0] unit_t;

  typedef struct packed {
    logic       valid;
    logic       zero;
    logic [2:0] neg;
  } fbv_ctl_t;

endpackage

@@ rtl/core/face_backface_visibility_alpha.sv @@
// ----------------------------------------------------------------------------
// face_backface_visibility_alpha
// Quad face visibility score (normal vs. view direction cosine) and alpha.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------
//  face in  | start_i & !busy_o    | v0_x_i .. v3_z_i
//  result   | done_o (one cycle)   | score_o, alpha_o, drawn_o, facing_o
//  config   | cfg_we_i             | cfg_idx_i, cfg_wdata_i
//
//  One beat per cycle; busy_o is always low. SHIFT_STEPS = clog2
//  of the widest vector magnitude sizes the justify stages; results
//  pass the root and divide stages. Reset clears valid bits and loads
//  the config registers with their defaults. No stalls anywhere.
// ----------------------------------------------------------------------------
module face_backface_visibility_alpha #(
  parameter int COORD_WIDTH     = 16,
  parameter int SCORE_FRAC_BITS = 14
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [COORD_WIDTH-1:0] v0_x_i,
  input  logic signed [COORD_WIDTH-1:0] v0_y_i,
  input  logic signed [COORD_WIDTH-1:0] v0_z_i,
  input  logic signed [COORD_WIDTH-1:0] v1_x_i,
  input  logic signed [COORD_WIDTH-1:0] v1_y_i,
  input  logic signed [COORD_WIDTH-1:0] v1_z_i,
  input  logic signed [COORD_WIDTH-1:0] v2_x_i,
  input  logic signed [COORD_WIDTH-1:0] v2_y_i,
  input  logic signed [COORD_WIDTH-1:0] v2_z_i,
  input  logic signed [COORD_WIDTH-1:0] v3_x_i,
  input  logic signed [COORD_WIDTH-1:0] v3_y_i,
  input  logic signed [COORD_WIDTH-1:0] v3_z_i,
  input  logic                          cfg_we_i,
  input  logic [fbv_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [fbv_pkg::CFG_W-1:0]     cfg_wdata_i,
  output logic                          done_o,
  output logic signed [SCORE_FRAC_BITS+1:0] score_o,
  output logic [fbv_pkg::ALPHA_W-1:0]   alpha_o,
  output logic                          drawn_o,
  output logic                          facing_o
);
  import fbv_pkg::*;

  localparam int C   = COORD_WIDTH;
  localparam int SW  = SCORE_FRAC_BITS + 2;
  localparam int EW  = C + 1;
  localparam int NW  = 2 * C + 2;
  localparam int NM  = 2 * C + 1;
  localparam int WM  = ((C + 1 > 18) ? C + 1 : 18) + 1;
  localparam int WW  = WM + 1;
  localparam int MX  = (NM > WM) ? NM : WM;
  localparam int STEPS = $clog2(MX);
  localparam int K   = 2 * UNIT_BITS - SCORE_FRAC_BITS;
  localparam logic signed [DOT_W-1:0] HALF = DOT_W'(1) <<< (K - 1);
  localparam logic signed [DOT_W-1:0] LIM  = DOT_W'(1) <<< SCORE_FRAC_BITS;

  logic [CFG_W-1:0]        view_q;
  logic signed [CFG_W-1:0] fade_low_q;
  logic signed [CFG_W-1:0] fade_high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      view_q      <= VIEW_DIST_RST;
      fade_low_q  <= FADE_LOW_RST;
      fade_high_q <= FADE_HIGH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_VIEW_DIST: view_q      <= cfg_wdata_i;
        CFG_FADE_LOW:  fade_low_q  <= cfg_wdata_i;
        CFG_FADE_HIGH: fade_high_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  logic signed [C-1:0]  vtx [4][3];
  logic signed [EW-1:0] e1_d [3], e2_d [3];
  logic signed [WW-1:0] wsum [3], w_d [3];

  assign vtx[0][0] = v0_x_i; assign vtx[0][1] = v0_y_i; assign vtx[0][2] = v0_z_i;
  assign vtx[1][0] = v1_x_i; assign vtx[1][1] = v1_y_i; assign vtx[1][2] = v1_z_i;
  assign vtx[2][0] = v2_x_i; assign vtx[2][1] = v2_y_i; assign vtx[2][2] = v2_z_i;
  assign vtx[3][0] = v3_x_i; assign vtx[3][1] = v3_y_i; assign vtx[3][2] = v3_z_i;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      e1_d[j] = EW'(vtx[1][j]) - EW'(vtx[0][j]);
      e2_d[j] = EW'(vtx[2][j]) - EW'(vtx[0][j]);
      wsum[j] = WW'(vtx[0][j]) + WW'(vtx[1][j]) + WW'(vtx[2][j]) + WW'(vtx[3][j]);
      w_d[j]  = -wsum[j];
    end
    w_d[2] = WW'({view_q, 2'b00}) - wsum[2];
  end

  logic s1_vld_q, s2_vld_q, s3_vld_q;
  logic signed [EW-1:0] e1_q [3], e2_q [3];
  logic signed [WW-1:0] w1_q [3], w2_q [3], w3_q [3];
  logic signed [NW-1:0] p_q [6];
  logic signed [NW-1:0] n_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= start_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    e1_q <= e1_d;
    e2_q <= e2_d;
    w1_q <= w_d;
    w2_q <= w1_q;
    w3_q <= w2_q;
    p_q[0] <= NW'(e1_q[1]) * NW'(e2_q[2]);
    p_q[1] <= NW'(e1_q[2]) * NW'(e2_q[1]);
    p_q[2] <= NW'(e1_q[2]) * NW'(e2_q[0]);
    p_q[3] <= NW'(e1_q[0]) * NW'(e2_q[2]);
    p_q[4] <= NW'(e1_q[0]) * NW'(e2_q[1]);
    p_q[5] <= NW'(e1_q[1]) * NW'(e2_q[0]);
    n_q[0] <= p_q[0] - p_q[1];
    n_q[1] <= p_q[2] - p_q[3];
    n_q[2] <= p_q[4] - p_q[5];
  end

  logic  nv_vld, n_zero, w_zero;
  unit_t un [3], uw [3];

  fbv_norm #(.VEC_MAG(NM), .SHIFT_STEPS(STEPS)) u_norm_n (
    .clk_i, .rst_ni, .valid_i(s3_vld_q), .vec_i(n_q),
    .valid_o(nv_vld), .zero_o(n_zero), .unit_o(un)
  );

  fbv_norm #(.VEC_MAG(WM), .SHIFT_STEPS(STEPS)) u_norm_w (
    .clk_i, .rst_ni, .valid_i(s3_vld_q), .vec_i(w3_q),
    .valid_o(), .zero_o(w_zero), .unit_o(uw)
  );

  logic d1_vld_q, d2_vld_q, d3_vld_q, d4_vld_q;
  logic d1_z_q, d2_z_q, d3_z_q;
  logic signed [DOT_W-1:0] dp_q [3];
  logic signed [DOT_W-1:0] dot_q, rnd_q;
  logic signed [SW-1:0]    score_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_vld_q <= 1'b0;
      d2_vld_q <= 1'b0;
      d3_vld_q <= 1'b0;
      d4_vld_q <= 1'b0;
    end else begin
      d1_vld_q <= nv_vld;
      d2_vld_q <= d1_vld_q;
      d3_vld_q <= d2_vld_q;
      d4_vld_q <= d3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      dp_q[i] <= DOT_W'(un[i]) * DOT_W'(uw[i]);
    end
    d1_z_q <= n_zero | w_zero;
    d2_z_q <= d1_z_q;
    d3_z_q <= d2_z_q;
    dot_q  <= dp_q[0] + dp_q[1] + dp_q[2];
    rnd_q  <= (dot_q + HALF) >>> K;
    if (d3_z_q) begin
      score_q <= '0;
    end else if (rnd_q > LIM) begin
      score_q <= SW'(LIM);
    end else if (rnd_q < -LIM) begin
      score_q <= SW'(-LIM);
    end else begin
      score_q <= SW'(rnd_q);
    end
  end

  fbv_alpha #(.SCORE_W(SW)) u_alpha (
    .clk_i, .rst_ni,
    .valid_i(d4_vld_q), .score_i(score_q),
    .fade_low_i(fade_low_q), .fade_high_i(fade_high_q),
    .done_o, .score_o, .alpha_o, .drawn_o, .facing_o
  );

endmodule

@@ rtl/core/fbv_norm.sv @@
// ----------------------------------------------------------------------------
// fbv_norm
// Pipelined vector normalizer: magnitude, power-of-two justify, sum of
// squares, bit-per-stage integer square root, bit-per-stage division.
// ----------------------------------------------------------------------------
module fbv_norm #(
  parameter int VEC_MAG     = 33,
  parameter int SHIFT_STEPS = 6
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic signed [VEC_MAG:0] vec_i [3],
  output logic                   valid_o,
  output logic                   zero_o,
  output fbv_pkg::unit_t         unit_o [3]
);
  import fbv_pkg::*;

  localparam int LAT = SHIFT_STEPS + SQRT_STEPS + DIV_STEPS + 7;

  fbv_ctl_t ctl_q [LAT];
  fbv_ctl_t ctl_d;

  logic [VEC_MAG-1:0] a_q [3];
  logic [VEC_MAG-1:0] b_a_q [3];
  logic [VEC_MAG-1:0] b_m_q;
  logic [VEC_MAG-1:0] js_a_q [SHIFT_STEPS+1][3];
  logic [VEC_MAG-1:0] js_m_q [SHIFT_STEPS+1];
  logic [UNIT_BITS-1:0]   a30 [3];
  logic [UNIT_BITS-1:0]   sq_a_q [3];
  logic [2*UNIT_BITS-1:0] sq_q [3];
  logic [SQ_W-1:0]        rx_q [SQRT_STEPS+1];
  logic [SQ_W-1:0]        rr_q [SQRT_STEPS+1];
  logic [UNIT_BITS-1:0]   ra_q [SQRT_STEPS+1][3];
  logic [DIV_W-1:0]       dr_q [DIV_STEPS+1][3];
  logic [ROOT_W-1:0]      dq_q [DIV_STEPS+1][3];
  logic [ROOT_W-1:0]      dl_q [DIV_STEPS+1];
  unit_t                  unit_q [3];

  always_comb begin
    ctl_d.valid = valid_i;
    ctl_d.zero  = (vec_i[0] == '0) && (vec_i[1] == '0) && (vec_i[2] == '0);
    for (int i = 0; i < 3; i++) begin
      ctl_d.neg[i] = vec_i[i][VEC_MAG];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < LAT; s++) begin
        ctl_q[s] <= '0;
      end
    end else begin
      ctl_q[0] <= ctl_d;
      for (int s = 1; s < LAT; s++) begin
        ctl_q[s] <= ctl_q[s-1];
      end
    end
  end

  // magnitude and two-step max
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      a_q[i]   <= VEC_MAG'(vec_i[i] < 0 ? -vec_i[i] : vec_i[i]);
      b_a_q[i] <= a_q[i];
      js_a_q[0][i] <= b_a_q[i];
    end
    b_m_q     <= (a_q[0] > a_q[1]) ? a_q[0] : a_q[1];
    js_m_q[0] <= (b_m_q > b_a_q[2]) ? b_m_q : b_a_q[2];
  end

  // left-justify the largest magnitude, one shift size per stage
  for (genvar j = 0; j < SHIFT_STEPS; j++) begin : g_js
    localparam int K = 1 << (SHIFT_STEPS - 1 - j);
    if (K < VEC_MAG) begin : g_sh
      always_ff @(posedge clk_i) begin
        if (js_m_q[j][VEC_MAG-1 -: K] == '0) begin
          js_m_q[j+1] <= js_m_q[j] << K;
          for (int i = 0; i < 3; i++) js_a_q[j+1][i] <= js_a_q[j][i] << K;
        end else begin
          js_m_q[j+1] <= js_m_q[j];
          for (int i = 0; i < 3; i++) js_a_q[j+1][i] <= js_a_q[j][i];
        end
      end
    end else begin : g_pass
      always_ff @(posedge clk_i) begin
        js_m_q[j+1] <= js_m_q[j];
        for (int i = 0; i < 3; i++) js_a_q[j+1][i] <= js_a_q[j][i];
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_a30
    if (VEC_MAG >= UNIT_BITS) begin : g_hi
      assign a30[i] = js_a_q[SHIFT_STEPS][i][VEC_MAG-1 -: UNIT_BITS];
    end else begin : g_lo
      assign a30[i] = {js_a_q[SHIFT_STEPS][i], (UNIT_BITS - VEC_MAG)'(0)};
    end
  end

  // squares, then their sum
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      sq_q[i]     <= (2*UNIT_BITS)'(a30[i]) * (2*UNIT_BITS)'(a30[i]);
      sq_a_q[i]   <= a30[i];
      ra_q[0][i]  <= sq_a_q[i];
    end
    rx_q[0] <= SQ_W'(sq_q[0]) + SQ_W'(sq_q[1]) + SQ_W'(sq_q[2]);
    rr_q[0] <= '0;
  end

  // integer square root, one root bit per stage
  for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_sqrt
    localparam logic [SQ_W:0] BIT = (SQ_W+1)'(1) << (2 * (SQRT_STEPS - 1 - s));
    logic [SQ_W:0] trial;
    assign trial = (SQ_W+1)'(rr_q[s]) + BIT;
    always_ff @(posedge clk_i) begin
      if ((SQ_W+1)'(rx_q[s]) >= trial) begin
        rx_q[s+1] <= SQ_W'((SQ_W+1)'(rx_q[s]) - trial);
        rr_q[s+1] <= SQ_W'((SQ_W+1)'(rr_q[s] >> 1) + BIT);
      end else begin
        rx_q[s+1] <= rx_q[s];
        rr_q[s+1] <= rr_q[s] >> 1;
      end
      for (int i = 0; i < 3; i++) ra_q[s+1][i] <= ra_q[s][i];
    end
  end

  always_ff @(posedge clk_i) begin
    dl_q[0] <= rr_q[SQRT_STEPS][ROOT_W-1:0];
    for (int i = 0; i < 3; i++) begin
      dr_q[0][i] <= DIV_W'({ra_q[SQRT_STEPS][i], UNIT_BITS'(0)});
      dq_q[0][i] <= '0;
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
    localparam int SH = DIV_STEPS - 1 - s;
    logic [DIV_W-1:0] dsh;
    assign dsh = DIV_W'(dl_q[s]) << SH;
    always_ff @(posedge clk_i) begin
      dl_q[s+1] <= dl_q[s];
      for (int i = 0; i < 3; i++) begin
        if (dr_q[s][i] >= dsh) begin
          dr_q[s+1][i] <= dr_q[s][i] - dsh;
          dq_q[s+1][i] <= dq_q[s][i] | (ROOT_W'(1) << SH);
        end else begin
          dr_q[s+1][i] <= dr_q[s][i];
          dq_q[s+1][i] <= dq_q[s][i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      unit_q[i] <= ctl_q[LAT-2].neg[i] ? -UNIT_W'(dq_q[DIV_STEPS][i])
                                        :  UNIT_W'(dq_q[DIV_STEPS][i]);
    end
  end

  assign valid_o = ctl_q[LAT-1].valid;
  assign zero_o  = ctl_q[LAT-1].zero;
  assign unit_o  = unit_q;

endmodule

@@ rtl/core/fbv_alpha.sv @@
// ----------------------------------------------------------------------------
// fbv_alpha
// Alpha ramp from the score: band compares, scale by 255, 8-stage divide.
// ----------------------------------------------------------------------------
module fbv_alpha #(
  parameter int SCORE_W = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic signed [SCORE_W-1:0]  score_i,
  input  logic signed [fbv_pkg::CFG_W-1:0] fade_low_i,
  input  logic signed [fbv_pkg::CFG_W-1:0] fade_high_i,
  output logic                       done_o,
  output logic signed [SCORE_W-1:0]  score_o,
  output logic [fbv_pkg::ALPHA_W-1:0] alpha_o,
  output logic                       drawn_o,
  output logic                       facing_o
);
  import fbv_pkg::*;

  localparam int CW   = ((SCORE_W > CFG_W) ? SCORE_W : CFG_W) + 2;
  localparam int NUMW = CW + ALPHA_W;
  localparam int NST  = ALPHA_W + 2;

  logic               vld_q [NST];
  logic               lo_q  [NST];
  logic               hi_q  [NST];
  logic               pos_q [NST];
  logic signed [SCORE_W-1:0] sc_q [NST];
  logic signed [CW-1:0]      diff_q;
  logic [CW-1:0]             den_q;
  logic [NUMW-1:0]           r_q [ALPHA_W+1];
  logic [ALPHA_W-1:0]        q_q [ALPHA_W+1];

  logic signed [CW-1:0] sc_w, lo_w, hi_w;
  assign sc_w = CW'(score_i);
  assign lo_w = CW'(fade_low_i);
  assign hi_w = CW'(fade_high_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NST; s++) vld_q[s] <= 1'b0;
      done_o <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
      for (int s = 1; s < NST; s++) vld_q[s] <= vld_q[s-1];
      done_o <= vld_q[NST-1];
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q[0]  <= sc_w <= lo_w;
    hi_q[0]  <= sc_w >= hi_w;
    pos_q[0] <= score_i > 0;
    sc_q[0]  <= score_i;
    diff_q   <= sc_w - lo_w;
    den_q    <= hi_w - lo_w;
    for (int s = 1; s < NST; s++) begin
      lo_q[s]  <= lo_q[s-1];
      hi_q[s]  <= hi_q[s-1];
      pos_q[s] <= pos_q[s-1];
      sc_q[s]  <= sc_q[s-1];
    end
    r_q[0] <= (NUMW'(diff_q) << ALPHA_W) - NUMW'(diff_q);
    q_q[0] <= '0;
  end

  for (genvar s = 0; s < ALPHA_W; s++) begin : g_div
    localparam int SH = ALPHA_W - 1 - s;
    logic [NUMW-1:0] dsh;
    assign dsh = NUMW'(den_q) << SH;
    always_ff @(posedge clk_i) begin
      if (r_q[s] >= dsh) begin
        r_q[s+1] <= r_q[s] - dsh;
        q_q[s+1] <= q_q[s] | (ALPHA_W'(1) << SH);
      end else begin
        r_q[s+1] <= r_q[s];
        q_q[s+1] <= q_q[s];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    score_o  <= sc_q[NST-1];
    drawn_o  <= !lo_q[NST-1];
    facing_o <= pos_q[NST-1];
    if (lo_q[NST-1]) begin
      alpha_o <= '0;
    end else if (hi_q[NST-1]) begin
      alpha_o <= ALPHA_MAX;
    end else begin
      alpha_o <= q_q[ALPHA_W];
    end
  end

endmodule
